### hw/rtl/apnv_pkg.sv
package apnv_pkg;

  localparam int COUNT_W = 13;
  localparam int LEVEL_W = 11;
  localparam int BYTE_W  = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [BYTE_W-1:0] DEL_BYTE   = 8'h7f;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3a;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PATH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SEGMENT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVELS  = 2'd2;

  localparam logic [COUNT_W-1:0] MAX_PATH_RESET    = 13'd1023;
  localparam logic [COUNT_W-1:0] MAX_SEGMENT_RESET = 13'd255;
  localparam logic [LEVEL_W-1:0] MAX_LEVELS_RESET  = 11'd64;

  typedef enum logic [3:0] {
    VERDICT_OK        = 4'd0,
    VERDICT_EMPTY     = 4'd1,
    VERDICT_ABSOLUTE  = 4'd2,
    VERDICT_DRIVE     = 4'd3,
    VERDICT_CONTROL   = 4'd4,
    VERDICT_EMPTY_SEG = 4'd5,
    VERDICT_DOT       = 4'd6,
    VERDICT_DOTDOT    = 4'd7,
    VERDICT_TOO_LONG  = 4'd8,
    VERDICT_COMP_LONG = 4'd9,
    VERDICT_TOO_DEEP  = 4'd10
  } verdict_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
  endfunction

endpackage

### hw/rtl/apnv_if.sv
interface apnv_in_if import apnv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              last_byte;

  modport source (output valid, name_byte, last_byte, input ready);
  modport sink (input valid, name_byte, last_byte, output ready);
endinterface

interface apnv_out_if import apnv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  clean_byte;
  logic               name_done;
  verdict_t           verdict;
  logic [LEVEL_W-1:0] depth_levels;

  modport source (output valid, clean_byte, name_done, verdict, depth_levels, input ready);
  modport sink (input valid, clean_byte, name_done, verdict, depth_levels, output ready);
endinterface

interface apnv_cfg_if import apnv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/archive_path_name_validator_top.sv
// Archive entry path validator. Name bytes stream in one per transfer, the final byte marked
// by last_byte, and each byte comes back as one result, through the input register and then
// the result register, with backslash turned into slash; the final byte's result carries
// the verdict and, on success, the component count. Throughput is one byte per cycle while
// results are taken, set by the running length, component and fault state, which is updated
// between the input register and the result register. The input side keeps accepting while
// a result waits to be taken, as long as the input register is empty. Limits must be written
// through the configuration channel only while no name is in flight; the block does not
// enforce this. NAME_BUFFER sets the name length at which the buffer-full fault is raised.
module archive_path_name_validator_top import apnv_pkg::*; #(
  parameter int NAME_BUFFER = 1024
) (
  input logic         clk,
  input logic         rst,
  apnv_in_if.sink     name_in,
  apnv_out_if.source  name_out,
  apnv_cfg_if.sink    cfg
);

  localparam logic [COUNT_W:0] BUFFER_LIMIT = (COUNT_W+1)'(NAME_BUFFER);

  // Limit registers.
  logic [COUNT_W-1:0] max_path_bytes;
  logic [COUNT_W-1:0] max_segment_bytes;
  logic [LEVEL_W-1:0] max_levels;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_path_bytes    <= MAX_PATH_RESET;
      max_segment_bytes <= MAX_SEGMENT_RESET;
      max_levels        <= MAX_LEVELS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAX_PATH:    max_path_bytes    <= cfg.data;
        REG_MAX_SEGMENT: max_segment_bytes <= cfg.data;
        REG_MAX_LEVELS:  max_levels        <= cfg.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;

  // Result register.
  logic               out_valid;
  logic [BYTE_W-1:0]  out_clean;
  logic               out_done;
  verdict_t           out_verdict;
  logic [LEVEL_W-1:0] out_depth;

  logic s2_load;
  logic s1_load;

  assign s2_load = s1_valid && (!out_valid || name_out.ready);
  assign s1_load = !s1_valid || s2_load;
  assign name_in.ready = s1_load;

  // Per-name state.
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] segment_count;
  logic [LEVEL_W-1:0] level_count;
  logic [BYTE_W-1:0]  prev_byte;
  logic [BYTE_W-1:0]  prev_prev_byte;
  logic [BYTE_W-1:0]  first_byte;
  verdict_t           first_fault;

  logic [COUNT_W-1:0] byte_count_next;
  logic [COUNT_W-1:0] segment_count_next;
  logic [LEVEL_W-1:0] level_count_next;
  logic [BYTE_W-1:0]  first_byte_next;
  verdict_t           first_fault_next;
  logic [BYTE_W-1:0]  clean;
  logic               is_sep;
  verdict_t           byte_fault;
  verdict_t           verdict_next;
  logic [LEVEL_W-1:0] depth_next;
  logic [LEVEL_W-1:0] levels;

  always_comb begin
    clean  = (s1_byte == CHAR_BSLASH) ? CHAR_SLASH : s1_byte;
    is_sep = (clean == CHAR_SLASH);
    first_byte_next = (byte_count == '0) ? s1_byte : first_byte;

    byte_fault = VERDICT_OK;
    if ((s1_byte < CTRL_LIMIT) || (s1_byte == DEL_BYTE)) begin
      byte_fault = VERDICT_CONTROL;
    end else if (is_sep) begin
      if (segment_count == '0) begin
        byte_fault = VERDICT_EMPTY_SEG;
      end else if ((segment_count == COUNT_W'(1)) && (prev_byte == CHAR_DOT)) begin
        byte_fault = VERDICT_DOT;
      end else if ((segment_count == COUNT_W'(2)) && (prev_byte == CHAR_DOT) &&
                   (prev_prev_byte == CHAR_DOT)) begin
        byte_fault = VERDICT_DOTDOT;
      end else if (segment_count > max_segment_bytes) begin
        byte_fault = VERDICT_COMP_LONG;
      end
    end else if ((byte_count == COUNT_W'(1)) && is_letter(first_byte) &&
                 (clean == CHAR_COLON)) begin
      byte_fault = VERDICT_DRIVE;
    end else if (({1'b0, byte_count} + (COUNT_W+1)'(2)) >= BUFFER_LIMIT) begin
      byte_fault = VERDICT_TOO_LONG;
    end
    first_fault_next = (first_fault == VERDICT_OK) ? byte_fault : first_fault;

    if (is_sep) begin
      segment_count_next = '0;
      level_count_next = (level_count < LEVEL_MAX) ? level_count + LEVEL_W'(1) : level_count;
    end else begin
      segment_count_next = (segment_count < COUNT_MAX) ? segment_count + COUNT_W'(1)
                                                       : segment_count;
      level_count_next = level_count;
    end
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + COUNT_W'(1) : byte_count;

    levels = (level_count_next < LEVEL_MAX) ? level_count_next + LEVEL_W'(1) : LEVEL_MAX;

    // Final-byte verdict, in order of precedence.
    verdict_next = VERDICT_OK;
    depth_next   = '0;
    if (s1_last) begin
      if (byte_count_next > max_path_bytes) begin
        verdict_next = VERDICT_TOO_LONG;
      end else if ((first_byte_next == CHAR_SLASH) || (first_byte_next == CHAR_BSLASH)) begin
        verdict_next = VERDICT_ABSOLUTE;
      end else if (first_fault_next != VERDICT_OK) begin
        verdict_next = first_fault_next;
      end else if (segment_count_next == '0) begin
        verdict_next = VERDICT_EMPTY;
      end else if ((segment_count_next == COUNT_W'(1)) && (clean == CHAR_DOT)) begin
        verdict_next = VERDICT_DOT;
      end else if ((segment_count_next == COUNT_W'(2)) && (clean == CHAR_DOT) &&
                   (prev_byte == CHAR_DOT)) begin
        verdict_next = VERDICT_DOTDOT;
      end else if (segment_count_next > max_segment_bytes) begin
        verdict_next = VERDICT_COMP_LONG;
      end else if (levels > max_levels) begin
        verdict_next = VERDICT_TOO_DEEP;
      end else begin
        depth_next = levels;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= name_in.valid;
    end
    if (s1_load) begin
      s1_byte <= name_in.name_byte;
      s1_last <= name_in.last_byte;
    end
  end

  // The per-name state advances as a byte moves into the result register; the final
  // byte clears it for the next name.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      segment_count  <= '0;
      level_count    <= '0;
      prev_byte      <= '0;
      prev_prev_byte <= '0;
      first_byte     <= '0;
      first_fault    <= VERDICT_OK;
    end else if (s2_load) begin
      if (s1_last) begin
        byte_count     <= '0;
        segment_count  <= '0;
        level_count    <= '0;
        prev_byte      <= '0;
        prev_prev_byte <= '0;
        first_byte     <= '0;
        first_fault    <= VERDICT_OK;
      end else begin
        byte_count     <= byte_count_next;
        segment_count  <= segment_count_next;
        level_count    <= level_count_next;
        prev_byte      <= clean;
        prev_prev_byte <= prev_byte;
        first_byte     <= first_byte_next;
        first_fault    <= first_fault_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || name_out.ready) begin
      out_valid <= s1_valid;
    end
    if (s2_load) begin
      out_clean   <= clean;
      out_done    <= s1_last;
      out_verdict <= verdict_next;
      out_depth   <= depth_next;
    end
  end

  assign name_out.valid        = out_valid;
  assign name_out.clean_byte   = out_clean;
  assign name_out.name_done    = out_done;
  assign name_out.verdict      = out_verdict;
  assign name_out.depth_levels = out_depth;

  a_mid_name_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_done) |-> (out_verdict == VERDICT_OK && out_depth == '0))
    else $error("verdict or depth set on a byte that does not end a name");

  a_depth_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_depth != '0) |-> (out_verdict == VERDICT_OK))
    else $error("depth reported with a failing verdict");

  a_ok_has_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done && out_verdict == VERDICT_OK) |-> (out_depth != '0))
    else $error("accepted name reported with zero depth");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (s2_load && s1_last) |=> (byte_count == '0 && level_count == '0 &&
                              first_fault == VERDICT_OK))
    else $error("name state not cleared after the final byte");

  a_no_backslash: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_clean != CHAR_BSLASH))
    else $error("backslash passed through unnormalized");

endmodule
